// ----- rtl/ata_pkg.sv -----
// package for the accelerometer tilt-angle pipeline
// holds the cordic arctangent table (degrees, 24 fraction bits) and shared widths
`default_nettype none
package ata_pkg;
    localparam int ACC_FRAC = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int SQ_W = 32;       // sum of two squares, up to 2^31
    localparam int RAD_W = 64;      // radicand sum << 32
    localparam int ROOT_W = 32;     // isqrt of the radicand
    localparam int VW = 52;         // cordic vector width, signed with growth
    localparam int ZW = 33;         // angle accumulator, signed

    function automatic logic [29:0] atan_tab(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0: v = 30'd754974720;
            5'd1: v = 30'd445687602;
            5'd2: v = 30'd235489088;
            5'd3: v = 30'd119537938;
            5'd4: v = 30'd60000934;
            5'd5: v = 30'd30029717;
            5'd6: v = 30'd15018523;
            5'd7: v = 30'd7509720;
            5'd8: v = 30'd3754917;
            5'd9: v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            default: v = 30'd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/ata_sqrt.sv -----
// pipelined integer square root, two result bits per stage
// uses ata_pkg widths; one stage per four radicand bits (two pairs)
`default_nettype none
module ata_sqrt
    import ata_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic      [ROOT_W-1:0] o_root
);
    localparam int NS = ROOT_W / 2;

    logic [RAD_W-1:0]  r_rem  [NS];
    logic [ROOT_W-1:0] r_root [NS];
    logic [RAD_W-1:0]  r_rad  [NS];

    // each stage resolves two root bits with two restoring steps
    function automatic void sq_step(input logic [RAD_W-1:0] rem, input logic [ROOT_W-1:0] root,
                                    input logic [1:0] pair, output logic [RAD_W-1:0] nrem,
                                    output logic [ROOT_W-1:0] nroot);
        logic [RAD_W+1:0] t;
        logic [RAD_W+1:0] trial;
        t = {rem, pair};
        trial = {{(RAD_W-ROOT_W){1'b0}}, root, 2'b01};
        if (t >= trial) begin
            nrem = RAD_W'(t - trial);
            nroot = {root[ROOT_W-2:0], 1'b1};
        end else begin
            nrem = RAD_W'(t);
            nroot = {root[ROOT_W-2:0], 1'b0};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        logic [RAD_W-1:0]  a_rem;
        logic [ROOT_W-1:0] a_root;
        logic [RAD_W-1:0]  b_rem;
        logic [ROOT_W-1:0] b_root;
        if (i_en) begin
            for (int s = 0; s < NS; s++) begin
                if (s == 0) begin
                    sq_step('0, '0, i_rad[RAD_W-1 -: 2], a_rem, a_root);
                    sq_step(a_rem, a_root, i_rad[RAD_W-3 -: 2], b_rem, b_root);
                    r_rad[s] <= i_rad << 4;
                end else begin
                    sq_step(r_rem[s-1], r_root[s-1], r_rad[s-1][RAD_W-1 -: 2], a_rem, a_root);
                    sq_step(a_rem, a_root, r_rad[s-1][RAD_W-3 -: 2], b_rem, b_root);
                    r_rad[s] <= r_rad[s-1] << 4;
                end
                r_rem[s]  <= b_rem;
                r_root[s] <= b_root;
            end
        end
    end

    assign o_root = r_root[NS-1];
endmodule
`default_nettype wire

// ----- rtl/ata_cordic.sv -----
// vectoring cordic pipeline giving atan2(p, c) in degrees, rounded output
// uses ata_pkg table; one registered stage per iteration
`default_nettype none
module ata_cordic
    import ata_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic signed [15:0] i_comp,
    input  wire logic [ROOT_W-1:0] i_perp,
    output logic      [15:0]       o_angle
);
    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] FULL = ZW'(180) <<< ACC_FRAC;
    localparam logic signed [ZW-1:0] QUART = ZW'(90) <<< ACC_FRAC;

    logic signed [VW-1:0] r_x [CORDIC_STEPS+1];
    logic signed [VW-1:0] r_y [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_z [CORDIC_STEPS+1];
    logic [15:0]          r_out;

    logic signed [VW-1:0] w_cs;
    logic signed [VW-1:0] w_p;
    assign w_cs = VW'(i_comp) <<< 16;
    assign w_p  = VW'({1'b0, i_perp});

    always_ff @(posedge i_clk) begin
        logic signed [VW-1:0] ys;
        logic signed [VW-1:0] xs;
        logic signed [ZW-1:0] t;
        logic signed [ZW+1:0] z;
        logic [ZW+1:0] rs;
        if (i_en) begin
            if (i_comp < 0) begin
                r_x[0] <= w_p;
                r_y[0] <= -w_cs;
                r_z[0] <= QUART;
            end else begin
                r_x[0] <= w_cs;
                r_y[0] <= w_p;
                r_z[0] <= '0;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                ys = r_y[i] >>> i;
                xs = r_x[i] >>> i;
                t = ZW'(atan_tab(5'(i)));
                if (!r_y[i][VW-1]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + t;
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - t;
                end
            end
            z = (ZW+2)'(r_z[CORDIC_STEPS]);
            if (z < 0) z = '0;
            if (z > (ZW+2)'(FULL)) z = (ZW+2)'(FULL);
            rs = ((ZW+2)'(z) + ((ZW+2)'(1) << (SH - 1))) >> SH;
            r_out <= (rs > (ZW+2)'(16'hFFFF)) ? 16'hFFFF : rs[15:0];
        end
    end

    assign o_angle = r_out;
endmodule
`default_nettype wire

// ----- rtl/accel_tilt_angles.sv -----
// accelerometer tilt angles: squares, pipelined isqrt, 24-step cordic per axis
// register stages: 1 + 1 + 16 + 25 + 1 = 44 (input, squares, isqrt, cordic, output)
// one beat per cycle while the output can take; the whole pipe advances only then
// reset: i_rst_n synchronous active low clears the valid bits; data has no reset
`default_nettype none
module accel_tilt_angles
    import ata_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // x_accel, y_accel, z_accel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata   // x_angle, y_angle, z_angle, angles_valid, pad
);
    localparam int LAT = 2 + ROOT_W / 2 + CORDIC_STEPS + 2;

    logic w_en;
    logic [LAT-1:0] r_vld;
    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // stage 1: register inputs
    logic signed [15:0] r_a [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a[0] <= s_axis_tdata[15:0];
            r_a[1] <= s_axis_tdata[31:16];
            r_a[2] <= s_axis_tdata[47:32];
        end
    end

    // stage 2: squares and pair sums
    logic [SQ_W-1:0] r_sum [3];
    logic signed [15:0] r_b [3];
    always_ff @(posedge i_clk) begin
        logic [30:0] sq [3];
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                sq[k] = 31'(32'(r_a[k] * r_a[k]));
                r_b[k] <= r_a[k];
            end
            r_sum[0] <= SQ_W'(sq[1]) + SQ_W'(sq[2]);
            r_sum[1] <= SQ_W'(sq[0]) + SQ_W'(sq[2]);
            r_sum[2] <= SQ_W'(sq[0]) + SQ_W'(sq[1]);
        end
    end

    // delay components alongside sqrt, and the zero flag alongside sqrt and cordic
    localparam int DS = ROOT_W / 2;
    logic signed [15:0] r_cd [DS][3];
    logic [DS+CORDIC_STEPS+1:0] r_zero;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int s = 0; s < DS; s++) begin
                for (int k = 0; k < 3; k++) begin
                    r_cd[s][k] <= (s == 0) ? r_b[k] : r_cd[s-1][k];
                end
            end
            r_zero <= {r_zero[DS+CORDIC_STEPS:0],
                       (r_b[0] == 0) && (r_b[1] == 0) && (r_b[2] == 0)};
        end
    end

    logic [15:0] w_ang [3];
    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic [ROOT_W-1:0] w_root;
        ata_sqrt u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  ({r_sum[k], 32'd0}),
            .o_root (w_root)
        );
        ata_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_comp  (r_cd[DS-1][k]),
            .i_perp  (w_root),
            .o_angle (w_ang[k])
        );
    end

    logic w_zero;
    assign w_zero = r_zero[DS+CORDIC_STEPS+1];
    assign m_axis_tdata = w_zero ? 56'd0
                                 : {7'd0, 1'b1, w_ang[2], w_ang[1], w_ang[0]};

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[47:0] == 48'd0)
        else $error("zero vector gave nonzero angle");
`endif
endmodule
`default_nettype wire
